[rtl/core/xor_float_stream_decoder_macros.svh]
// assertion macros shared by the xor float stream decoder rtl
`ifndef XOR_FLOAT_STREAM_DECODER_MACROS_SVH
`define XOR_FLOAT_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define XFSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xfsd: implication check failed");

// next-cycle implication, disabled during reset
`define XFSD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xfsd: next-cycle check failed");

`endif

[rtl/core/xfsd_pkg.sv]
// shared constants, types and helpers of the xor float stream decoder
`default_nettype none

package xfsd_pkg;

    localparam int XFSD_TABLE_DEPTH = 32;
    localparam int XFSD_VALUE_W     = 64;
    localparam int XFSD_IDX_W       = 5;
    localparam int XFSD_ENTRY_W     = 6;
    localparam int XFSD_COUNT_W     = 5;
    localparam int XFSD_ACC_W       = 10;
    localparam int XFSD_REM_W       = 7;
    localparam int XFSD_IW_W        = 3;
    localparam int XFSD_POS_W       = 6;

    localparam logic [XFSD_VALUE_W-1:0] XFSD_NAN_BITS     = 64'h7ff8_0000_0000_0000;
    localparam logic [XFSD_VALUE_W-1:0] XFSD_INIT_DEFAULT = 64'h4000_0000_0000_0000;

    // parse position within the bit stream
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_UPD,
        PH_LCOUNT,
        PH_LENTRY,
        PH_TCOUNT,
        PH_TENTRY,
        PH_CTRL1,
        PH_CTRL2,
        PH_INDEX,
        PH_LOAD,
        PH_CENTER
    } xfsd_phase_t;

    // table memory accesses requested by the parser
    typedef struct packed {
        logic                    wr_lead;
        logic                    wr_trail;
        logic [XFSD_IDX_W-1:0]   wr_addr;
        logic [XFSD_ENTRY_W-1:0] wr_data;
        logic                    rd_en;
        logic [XFSD_IDX_W-1:0]   rd_lead;
        logic [XFSD_IDX_W-1:0]   rd_trail;
    } xfsd_tbl_req_t;

    // decoded value handed to the output register
    typedef struct packed {
        logic                    valid;
        logic [XFSD_VALUE_W-1:0] value;
        logic                    last;
    } xfsd_emit_t;

    // bits needed to index a table of n entries, zero for one entry
    function automatic logic [XFSD_IW_W-1:0] xfsd_index_width(input logic [5:0] n);
        logic [XFSD_IW_W-1:0] w;
        if (n <= 6'd1) begin
            w = 3'd0;
        end else if (n <= 6'd2) begin
            w = 3'd1;
        end else if (n <= 6'd4) begin
            w = 3'd2;
        end else if (n <= 6'd8) begin
            w = 3'd3;
        end else if (n <= 6'd16) begin
            w = 3'd4;
        end else begin
            w = 3'd5;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/xfsd_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module xfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/xfsd_parser.sv]
// bit-serial parser: headers, table loads, control codes and center bits
`default_nettype none

module xfsd_parser #(
    parameter int TABLE_DEPTH = xfsd_pkg::XFSD_TABLE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              in_bit,
    input  wire logic                              in_start,
    input  wire logic                              out_free,
    input  wire logic                              cfg_we,
    input  wire logic [xfsd_pkg::XFSD_VALUE_W-1:0] cfg_data,
    output xfsd_pkg::xfsd_tbl_req_t                tbl_req,
    input  wire logic [xfsd_pkg::XFSD_ENTRY_W-1:0] lead_rdata,
    input  wire logic [xfsd_pkg::XFSD_ENTRY_W-1:0] trail_rdata,
    output xfsd_pkg::xfsd_emit_t                   emit
);

    import xfsd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    xfsd_phase_t phase_reg, phase_next;

    logic                      wem_reg, wem_next;
    logic [XFSD_ENTRY_W-1:0]   lz_reg, lz_next;
    logic [XFSD_ENTRY_W-1:0]   tz_reg, tz_next;
    logic [XFSD_IW_W-1:0]      liw_reg, liw_next;
    logic [XFSD_IW_W-1:0]      tiw_reg, tiw_next;
    logic [XFSD_ACC_W-1:0]     acc_reg, acc_next;
    logic [XFSD_REM_W-1:0]     rem_reg, rem_next;
    logic [5:0]                ent_reg, ent_next;
    logic [5:0]                wp_reg, wp_next;
    logic [XFSD_POS_W-1:0]     pos_reg, pos_next;
    logic [XFSD_VALUE_W-1:0]   mask_reg, mask_next;
    logic [XFSD_VALUE_W-1:0]   prev_reg, prev_next;
    logic                      rd_ok_l_reg, rd_ok_l_next;
    logic                      rd_ok_t_reg, rd_ok_t_next;
    logic [TABLE_DEPTH-1:0]    lvalid_reg, lvalid_next;
    logic [TABLE_DEPTH-1:0]    tvalid_reg, tvalid_next;

    xfsd_phase_t               eff_phase;
    logic [XFSD_REM_W-1:0]     eff_rem;
    logic [XFSD_POS_W-1:0]     eff_pos;
    logic [XFSD_VALUE_W-1:0]   eff_mask;

    logic [XFSD_ENTRY_W-1:0]   lz_rd, tz_rd;
    logic [XFSD_REM_W-1:0]     load_sum;
    logic                      load_emit;
    logic                      accept;
    logic [XFSD_ACC_W-1:0]     acc_shift;
    logic [XFSD_ACC_W-1:0]     acc_lead;
    logic [XFSD_REM_W-1:0]     rem_dec;
    logic [XFSD_REM_W-1:0]     ctr_sum;
    logic [XFSD_IW_W:0]        idx_w;
    logic [XFSD_IDX_W-1:0]     trail_mask;
    logic [XFSD_IDX_W-1:0]     rd_lead_sel, rd_trail_sel;
    logic                      rd_ok_l, rd_ok_t;
    logic [5:0]                cnt_n;
    logic [XFSD_VALUE_W-1:0]   mask_new;
    logic                      wp_in_range;

    // zero counts as read back from the tables, unwritten slots read zero
    assign lz_rd     = rd_ok_l_reg ? lead_rdata : '0;
    assign tz_rd     = rd_ok_t_reg ? trail_rdata : '0;
    assign load_sum  = {1'b0, lz_rd} + {1'b0, tz_rd};
    assign load_emit = (phase_reg == PH_LOAD) && load_sum[XFSD_REM_W-1];

    assign in_ready = out_free && !load_emit;
    assign accept   = in_valid && in_ready;

    // field arithmetic
    assign acc_shift  = {acc_reg[XFSD_ACC_W-2:0], in_bit};
    assign rem_dec    = (eff_rem != '0) ? eff_rem - 1'b1 : '0;
    assign ctr_sum    = {1'b0, lz_reg} + {1'b0, tz_reg};
    assign idx_w      = {1'b0, liw_reg} + {1'b0, tiw_reg};
    assign trail_mask = (XFSD_IDX_W'(1) << tiw_reg) - XFSD_IDX_W'(1);
    assign acc_lead   = acc_shift >> tiw_reg;
    assign cnt_n      = (acc_shift[XFSD_COUNT_W-1:0] == '0) ? 6'd32
                                                           : {1'b0, acc_shift[XFSD_COUNT_W-1:0]};
    assign mask_new   = eff_mask | (XFSD_VALUE_W'(in_bit) << eff_pos);
    assign wp_in_range = (wp_reg < 6'(TABLE_DEPTH));

    // table indices, both zero when no index bits are sent
    assign rd_lead_sel  = (idx_w == '0) ? '0 : acc_lead[XFSD_IDX_W-1:0];
    assign rd_trail_sel = (idx_w == '0) ? '0 : (acc_shift[XFSD_IDX_W-1:0] & trail_mask);
    assign rd_ok_l = ({1'b0, rd_lead_sel} < 6'(TABLE_DEPTH)) && lvalid_reg[rd_lead_sel[AW-1:0]];
    assign rd_ok_t = ({1'b0, rd_trail_sel} < 6'(TABLE_DEPTH))
                     && tvalid_reg[rd_trail_sel[AW-1:0]];

    // next state, table requests and emission
    always_comb begin
        phase_next   = phase_reg;
        wem_next     = wem_reg;
        lz_next      = lz_reg;
        tz_next      = tz_reg;
        liw_next     = liw_reg;
        tiw_next     = tiw_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        ent_next     = ent_reg;
        wp_next      = wp_reg;
        pos_next     = pos_reg;
        mask_next    = mask_reg;
        prev_next    = prev_reg;
        rd_ok_l_next = rd_ok_l_reg;
        rd_ok_t_next = rd_ok_t_reg;
        lvalid_next  = lvalid_reg;
        tvalid_next  = tvalid_reg;
        tbl_req      = '0;
        emit         = '0;
        eff_phase    = phase_reg;
        eff_rem      = rem_reg;
        eff_pos      = pos_reg;
        eff_mask     = mask_reg;

        // table data has arrived: settle the zero counts
        if (phase_reg == PH_LOAD) begin
            lz_next = lz_rd;
            tz_next = tz_rd;
            if (load_sum[XFSD_REM_W-1]) begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    emit.value = prev_reg;
                end
            end else begin
                eff_phase  = PH_CENTER;
                eff_rem    = XFSD_REM_W'(64) - load_sum;
                eff_pos    = ~lz_rd;
                eff_mask   = '0;
                phase_next = PH_CENTER;
                rem_next   = eff_rem;
                pos_next   = eff_pos;
                mask_next  = '0;
            end
        end

        if (accept) begin
            if (in_start) begin
                // window-mode bit of a new block
                wem_next   = in_bit;
                phase_next = PH_UPD;
                rem_next   = '0;
                acc_next   = '0;
            end else begin
                case (eff_phase)
                    PH_UPD: begin
                        if (in_bit) begin
                            phase_next = PH_LCOUNT;
                            rem_next   = XFSD_REM_W'(XFSD_COUNT_W);
                            acc_next   = '0;
                        end else begin
                            phase_next = PH_CTRL1;
                        end
                    end
                    PH_CTRL1, PH_CTRL2: begin
                        if (!in_bit && eff_phase == PH_CTRL1) begin
                            phase_next = PH_CTRL2;
                        end else if (!in_bit) begin
                            // new table indices
                            if (idx_w == '0) begin
                                tbl_req.rd_en    = 1'b1;
                                tbl_req.rd_lead  = rd_lead_sel;
                                tbl_req.rd_trail = rd_trail_sel;
                                rd_ok_l_next     = rd_ok_l;
                                rd_ok_t_next     = rd_ok_t;
                                phase_next       = PH_LOAD;
                            end else begin
                                phase_next = PH_INDEX;
                                rem_next   = XFSD_REM_W'(idx_w);
                                acc_next   = '0;
                            end
                        end else if (wem_reg == (eff_phase == PH_CTRL1)
                                     || ctr_sum[XFSD_REM_W-1]) begin
                            // repeat, or reuse with no center bits
                            emit.valid = 1'b1;
                            emit.value = prev_reg;
                        end else begin
                            phase_next = PH_CENTER;
                            rem_next   = XFSD_REM_W'(64) - ctr_sum;
                            pos_next   = ~lz_reg;
                            mask_next  = '0;
                        end
                    end
                    PH_LCOUNT, PH_TCOUNT, PH_LENTRY, PH_TENTRY, PH_INDEX: begin
                        acc_next = acc_shift;
                        rem_next = rem_dec;
                        if (rem_dec == '0) begin
                            case (eff_phase)
                                PH_LCOUNT, PH_TCOUNT: begin
                                    if (eff_phase == PH_LCOUNT) begin
                                        liw_next   = xfsd_index_width(cnt_n);
                                        phase_next = PH_LENTRY;
                                    end else begin
                                        tiw_next   = xfsd_index_width(cnt_n);
                                        phase_next = PH_TENTRY;
                                    end
                                    ent_next = cnt_n;
                                    wp_next  = '0;
                                    rem_next = XFSD_REM_W'(XFSD_ENTRY_W);
                                    acc_next = '0;
                                end
                                PH_LENTRY, PH_TENTRY: begin
                                    if (wp_in_range) begin
                                        tbl_req.wr_lead  = (eff_phase == PH_LENTRY);
                                        tbl_req.wr_trail = (eff_phase == PH_TENTRY);
                                        tbl_req.wr_addr  = wp_reg[XFSD_IDX_W-1:0];
                                        tbl_req.wr_data  = acc_shift[XFSD_ENTRY_W-1:0];
                                        if (eff_phase == PH_LENTRY) begin
                                            lvalid_next[wp_reg[AW-1:0]] = 1'b1;
                                        end else begin
                                            tvalid_next[wp_reg[AW-1:0]] = 1'b1;
                                        end
                                    end
                                    wp_next  = wp_reg + 6'd1;
                                    ent_next = (ent_reg != '0) ? ent_reg - 6'd1 : '0;
                                    acc_next = '0;
                                    if (ent_next != '0) begin
                                        rem_next = XFSD_REM_W'(XFSD_ENTRY_W);
                                    end else if (eff_phase == PH_LENTRY) begin
                                        phase_next = PH_TCOUNT;
                                        rem_next   = XFSD_REM_W'(XFSD_COUNT_W);
                                    end else begin
                                        phase_next = PH_CTRL1;
                                    end
                                end
                                default: begin
                                    // index complete: look up both zero counts
                                    tbl_req.rd_en    = 1'b1;
                                    tbl_req.rd_lead  = rd_lead_sel;
                                    tbl_req.rd_trail = rd_trail_sel;
                                    rd_ok_l_next     = rd_ok_l;
                                    rd_ok_t_next     = rd_ok_t;
                                    phase_next       = PH_LOAD;
                                end
                            endcase
                        end
                    end
                    PH_CENTER: begin
                        // each center bit lands directly at its final position
                        mask_next = mask_new;
                        pos_next  = eff_pos - 1'b1;
                        rem_next  = rem_dec;
                        if (rem_dec == '0) begin
                            emit.valid = 1'b1;
                            emit.value = prev_reg ^ mask_new;
                        end
                    end
                    default: begin
                        // idle: bits outside a block are dropped
                    end
                endcase
            end
        end

        // emission ends the value; the terminator is not kept
        if (emit.valid) begin
            emit.last = (emit.value == XFSD_NAN_BITS);
            if (emit.last) begin
                phase_next = PH_IDLE;
            end else begin
                prev_next  = emit.value;
                phase_next = PH_CTRL1;
            end
        end

        if (cfg_we) begin
            prev_next = cfg_data;
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // datapath and bookkeeping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wem_reg     <= 1'b0;
            lz_reg      <= '0;
            tz_reg      <= '0;
            liw_reg     <= '0;
            tiw_reg     <= '0;
            rem_reg     <= '0;
            ent_reg     <= '0;
            wp_reg      <= '0;
            rd_ok_l_reg <= 1'b0;
            rd_ok_t_reg <= 1'b0;
            lvalid_reg  <= '0;
            tvalid_reg  <= '0;
            prev_reg    <= XFSD_INIT_DEFAULT;
        end else begin
            wem_reg     <= wem_next;
            lz_reg      <= lz_next;
            tz_reg      <= tz_next;
            liw_reg     <= liw_next;
            tiw_reg     <= tiw_next;
            rem_reg     <= rem_next;
            ent_reg     <= ent_next;
            wp_reg      <= wp_next;
            rd_ok_l_reg <= rd_ok_l_next;
            rd_ok_t_reg <= rd_ok_t_next;
            lvalid_reg  <= lvalid_next;
            tvalid_reg  <= tvalid_next;
            prev_reg    <= prev_next;
        end
    end

    // field accumulators, always loaded before use
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        pos_reg  <= pos_next;
        mask_reg <= mask_next;
    end

endmodule

`default_nettype wire

[rtl/core/xor_float_stream_decoder.sv]
// top level of the bit-serial xor float stream decoder
//
//   channel   direction  payload                                 handshake
//   s_        in         tdata[0] stream_bit, tuser block_start  tvalid/tready
//   m_        out        tdata value_bits, tlast end_of_block    tvalid/tready
//   cfg_      in         wr_data initial_value                   wr_en
//
// one stream bit is taken per cycle while the output register is free; a
// bit that completes a value puts the result into the output register in
// the same cycle. after an index field the zero-count tables are read; when
// the registered ram data arrives, if the two counts sum to 64 or more the
// previous value is sent and no bit is taken, else the next bit flows on.
// reset is synchronous; table slots read as zero until written (valid bits).
// a result waiting in the output register does not block input while the
// sink takes it in the same cycle.
`default_nettype none

`include "xor_float_stream_decoder_macros.svh"

module xor_float_stream_decoder #(
    parameter int TABLE_DEPTH = xfsd_pkg::XFSD_TABLE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // bits: [0] stream_bit, [7:1] zero
    input  wire logic [7:0]                        s_tdata,
    // bits: [0] block_start
    input  wire logic                              s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // bits: [63:0] value_bits
    output logic [xfsd_pkg::XFSD_VALUE_W-1:0]      m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [xfsd_pkg::XFSD_VALUE_W-1:0] cfg_wr_data
);

    import xfsd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    xfsd_tbl_req_t            tbl_req;
    xfsd_emit_t               emit;
    logic [XFSD_ENTRY_W-1:0]  lead_rdata, trail_rdata;
    logic                     out_free;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [XFSD_VALUE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg, m_tlast_next;

    assign out_free = !m_tvalid_reg || m_tready;

    // stream parser
    xfsd_parser #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_bit      (s_tdata[0]),
        .in_start    (s_tuser),
        .out_free    (out_free),
        .cfg_we      (cfg_wr_en),
        .cfg_data    (cfg_wr_data),
        .tbl_req     (tbl_req),
        .lead_rdata  (lead_rdata),
        .trail_rdata (trail_rdata),
        .emit        (emit)
    );

    // leading zero-count table
    xfsd_ram #(
        .WIDTH (XFSD_ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_lead_ram (
        .aclk    (aclk),
        .wr_en   (tbl_req.wr_lead),
        .wr_addr (tbl_req.wr_addr[AW-1:0]),
        .wr_data (tbl_req.wr_data),
        .rd_en   (tbl_req.rd_en),
        .rd_addr (tbl_req.rd_lead[AW-1:0]),
        .rd_data (lead_rdata)
    );

    // trailing zero-count table
    xfsd_ram #(
        .WIDTH (XFSD_ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_trail_ram (
        .aclk    (aclk),
        .wr_en   (tbl_req.wr_trail),
        .wr_addr (tbl_req.wr_addr[AW-1:0]),
        .wr_data (tbl_req.wr_data),
        .rd_en   (tbl_req.rd_en),
        .rd_addr (tbl_req.rd_trail[AW-1:0]),
        .rd_data (trail_rdata)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit.value;
            m_tlast_next  = emit.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    `XFSD_ASSERT_IMP(a_emit_has_slot, aclk, aresetn, emit.valid, out_free)
    `XFSD_ASSERT_IMP(a_take_has_slot, aclk, aresetn, s_tvalid && s_tready, out_free)
    `XFSD_ASSERT_IMP(a_last_is_nan, aclk, aresetn, m_tvalid, m_tlast == (m_tdata == XFSD_NAN_BITS))
    `XFSD_ASSERT_NEXT(a_emit_lands, aclk, aresetn, emit.valid, m_tvalid && m_tdata == $past(emit.value))

endmodule

`default_nettype wire
